### src/dvrt_pkg.sv
`timescale 1ns / 1ps

package dvrt_pkg;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_INIT   = 3'd2,
      OP_VECTOR = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK          = 2'd0,
      ERR_NO_NEIGHBOR = 2'd1,
      ERR_NO_DEST     = 2'd2
   } error_type;

   localparam logic [3:0] CSR_SELF_NODE  = 4'd0;
   localparam logic [3:0] CSR_NODE_COUNT = 4'd1;

   localparam logic [4:0] NODE_COUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  neighbor;
      logic [3:0]  destination;
      logic [15:0] cost;
      logic        last;
   } req_payload_type;

   typedef struct packed {
      logic        entry_changed;
      logic        vector_changed;
      logic [1:0]  error;
      logic [15:0] route_cost;
      logic [4:0]  route_hop;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0] index;
      logic [7:0] data;
   } csr_payload_type;

endpackage

### src/dvrt_chan_if.sv
`timescale 1ns / 1ps

interface dvrt_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/dvrt_ram.sv
`timescale 1ns / 1ps

module dvrt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

### src/distance_vector_route_table.sv
`timescale 1ns / 1ps

// Distance-vector route table with a Bellman-Ford update step.
// Beats arrive on req_if (op, neighbor, destination, cost, last); every request
// beat produces exactly one response beat on rsp_if, in order. Registers are
// written on csr_if (index 0 self node, index 1 node count), which is always
// ready and must only be used while no request is outstanding.
// Add, vector entry, read and undefined ops, and a remove of an out-of-range
// neighbor: the beat is accepted in idle, the response is registered in the exec
// state once the output register can take it, and the next request is accepted
// after the return to idle. The route and link memories have registered reads.
// Init and an in-range remove sweep the route memory one entry a cycle, then
// drain the pipeline and return to idle once the response can be loaded.
// Reset clears the neighbor and route valid bits at once, so every route reads
// as infinite with no next hop; no clearing pass is needed.
// The response is held in an output register; a new request is accepted while
// it waits, but that request completes only once the receiver takes the
// pending response beat.
module distance_vector_route_table #(
   parameter int NODES     = 16,
   parameter int COST_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   dvrt_chan_if.sink   req_if,
   dvrt_chan_if.source rsp_if,
   dvrt_chan_if.sink   csr_if
);
   import dvrt_pkg::*;

   localparam int IDX_W  = $clog2(NODES);
   localparam int HOP_W  = $clog2(NODES + 1);
   localparam int RT_W   = COST_BITS + HOP_W;
   localparam logic [HOP_W-1:0]     NO_HOP   = HOP_W'(NODES);
   localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};
   localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(NODES - 1);

   state_type state_ff, state_in;
   req_payload_type item_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_load, can_load;
   logic [3:0] self_ff;
   logic [4:0] count_ff;
   logic [NODES-1:0] present_ff, present_in;
   logic [NODES-1:0] valid_ff, valid_in;
   logic acc_ff, acc_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic p_vld_ff, p_vld_in;
   logic [IDX_W-1:0] p_idx_ff;

   logic req_acc;
   logic rt_wr_en, rt_rd_en, lc_wr_en, lc_rd_en;
   logic [IDX_W-1:0] rt_wr_addr, rt_rd_addr, lc_wr_addr, lc_rd_addr;
   logic [RT_W-1:0] rt_wr_data, rt_rd_data;
   logic [COST_BITS-1:0] lc_wr_data, lc_rd_data;

   logic [IDX_W-1:0] nb_idx, dst_idx;
   logic nb_in_range, nb_ok, known_dst;
   logic [COST_BITS-1:0] in_cost, cur_cost, total;
   logic [HOP_W-1:0] cur_hop;
   logic [COST_BITS:0] sum;
   logic hop_is_nb, adopt;
   logic p_known, p_self, p_match;

   dvrt_ram #(.WIDTH(RT_W), .DEPTH(NODES)) route_ram (
      .clock   (clock),
      .wr_en   (rt_wr_en),
      .wr_addr (rt_wr_addr),
      .wr_data (rt_wr_data),
      .rd_en   (rt_rd_en),
      .rd_addr (rt_rd_addr),
      .rd_data (rt_rd_data)
   );

   dvrt_ram #(.WIDTH(COST_BITS), .DEPTH(NODES)) link_ram (
      .clock   (clock),
      .wr_en   (lc_wr_en),
      .wr_addr (lc_wr_addr),
      .wr_data (lc_wr_data),
      .rd_en   (lc_rd_en),
      .rd_addr (lc_rd_addr),
      .rd_data (lc_rd_data)
   );

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;
   assign req_acc  = req_if.valid && req_if.ready;
   assign can_load = !rsp_valid_ff || rsp_if.ready;

   assign nb_idx      = IDX_W'(item_ff.neighbor);
   assign dst_idx     = IDX_W'(item_ff.destination);
   assign nb_in_range = 32'(item_ff.neighbor) < NODES;
   assign nb_ok       = nb_in_range && present_ff[nb_idx];
   assign known_dst   = (32'(item_ff.destination) < 32'(count_ff))
                        && (32'(item_ff.destination) < NODES);
   assign in_cost     = COST_BITS'(item_ff.cost);
   assign cur_cost    = valid_ff[dst_idx] ? rt_rd_data[RT_W-1:HOP_W] : COST_INF;
   assign cur_hop     = valid_ff[dst_idx] ? rt_rd_data[HOP_W-1:0] : NO_HOP;
   assign sum         = {1'b0, lc_rd_data} + {1'b0, in_cost};
   assign total       = (sum >= {1'b0, COST_INF}) ? COST_INF : sum[COST_BITS-1:0];
   assign hop_is_nb   = 32'(cur_hop) == 32'(item_ff.neighbor);
   assign adopt       = (total < cur_cost) || (hop_is_nb && (total != cur_cost));

   assign p_known = 32'(p_idx_ff) < 32'(count_ff);
   assign p_self  = 32'(p_idx_ff) == 32'(self_ff);
   assign p_match = valid_ff[p_idx_ff]
                    && (32'(rt_rd_data[HOP_W-1:0]) == 32'(item_ff.neighbor));

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      present_in = present_ff;
      valid_in   = valid_ff;
      acc_in     = acc_ff;
      rsp_load   = 1'b0;
      rsp_in     = '0;
      p_vld_in   = 1'b0;
      rt_rd_en   = 1'b0;
      lc_rd_en   = 1'b0;
      rt_rd_addr = IDX_W'(req_if.payload.destination);
      lc_rd_addr = IDX_W'(req_if.payload.neighbor);
      rt_wr_en   = 1'b0;
      rt_wr_addr = dst_idx;
      rt_wr_data = {total, HOP_W'(item_ff.neighbor)};
      lc_wr_en   = 1'b0;
      lc_wr_addr = nb_idx;
      lc_wr_data = in_cost;

      if (p_vld_ff) begin
         if (item_ff.op == OP_INIT) begin
            if (p_known && p_self) begin
               rt_wr_en   = 1'b1;
               rt_wr_addr = p_idx_ff;
               rt_wr_data = {{COST_BITS{1'b0}}, HOP_W'(self_ff)};
               valid_in[p_idx_ff] = 1'b1;
            end else if (p_known && present_ff[p_idx_ff]) begin
               rt_wr_en   = 1'b1;
               rt_wr_addr = p_idx_ff;
               rt_wr_data = {lc_rd_data, HOP_W'(p_idx_ff)};
               valid_in[p_idx_ff] = 1'b1;
            end else begin
               valid_in[p_idx_ff] = 1'b0;
            end
         end else if (p_match) begin
            valid_in[p_idx_ff] = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               rt_rd_en = 1'b1;
               lc_rd_en = 1'b1;
               cnt_in   = '0;
               if (req_if.payload.op == OP_INIT) begin
                  state_in = ST_SWEEP;
               end else if (req_if.payload.op == OP_REMOVE
                            && 32'(req_if.payload.neighbor) < NODES) begin
                  present_in[IDX_W'(req_if.payload.neighbor)] = 1'b0;
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_SWEEP: begin
            rt_rd_en   = 1'b1;
            lc_rd_en   = 1'b1;
            rt_rd_addr = cnt_ff;
            lc_rd_addr = cnt_ff;
            p_vld_in   = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (can_load) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EXEC: begin
            if (can_load) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               case (item_ff.op)
                  OP_ADD: begin
                     if (nb_in_range) begin
                        lc_wr_en = 1'b1;
                        present_in[nb_idx] = 1'b1;
                     end
                  end
                  OP_VECTOR: begin
                     if (!nb_ok) begin
                        rsp_in.error = ERR_NO_NEIGHBOR;
                     end else if (item_ff.destination == self_ff || in_cost == COST_INF) begin
                        rsp_in.error = ERR_OK;
                     end else if (!known_dst) begin
                        rsp_in.error = ERR_NO_DEST;
                     end else if (adopt) begin
                        rt_wr_en = 1'b1;
                        valid_in[dst_idx] = 1'b1;
                        rsp_in.entry_changed = 1'b1;
                     end
                     rsp_in.vector_changed = acc_ff || rsp_in.entry_changed;
                     acc_in = item_ff.last ? 1'b0 : rsp_in.vector_changed;
                  end
                  OP_READ: begin
                     if (!known_dst) begin
                        rsp_in.error = ERR_NO_DEST;
                     end else begin
                        rsp_in.route_cost = 16'(cur_cost);
                        rsp_in.route_hop  = 5'(cur_hop);
                     end
                  end
                  default: begin
                     rsp_in = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         present_ff   <= '0;
         valid_ff     <= '0;
         acc_ff       <= 1'b0;
         cnt_ff       <= '0;
         p_vld_ff     <= 1'b0;
         self_ff      <= '0;
         count_ff     <= NODE_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         present_ff   <= present_in;
         valid_ff     <= valid_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         p_vld_ff     <= p_vld_in;
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.payload.index)
               CSR_SELF_NODE:  self_ff  <= csr_if.payload.data[3:0];
               CSR_NODE_COUNT: count_ff <= csr_if.payload.data[4:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         item_ff <= req_if.payload;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      p_idx_ff <= cnt_ff;
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != ST_IDLE)
      else $error("request beat accepted but block stayed idle");

   a_sweep_stage_in_sweep: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("sweep pipeline active outside a sweep");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff == ST_EXEC || state_ff == ST_DRAIN) && can_load)
      else $error("response loaded outside a finishing state");
`endif
endmodule
